@@ rtl/lpe_pkg.sv @@
// Package for the LSB payload extractor.
// Holds shared constants, register codes, the configuration struct and the chunk mask function.
// No dependencies.
package lpe_pkg;

  // Default header length in rebuilt bytes
  localparam int unsigned LPE_HEADER_BYTES = 4;

  // Width of the length field built from the header
  localparam int unsigned LEN_W = 32;

  // Smallest usable scanline size (filter byte plus one data byte)
  localparam logic [15:0] LINE_SIZE_MIN = 16'd2;

  // Register indexes on the configuration port (byte address 4 * index)
  localparam logic REG_BIT_DEPTH = 1'b0;
  localparam logic REG_LINE_SIZE = 1'b1;

  // Configuration register contents
  typedef struct packed {
    logic [1:0]  bit_depth_code;
    logic [15:0] line_size;
  } cfg_t;

  // Mask of the low bits taken from each image byte for a depth code
  function automatic logic [7:0] chunk_mask(input logic [1:0] code);
    logic [7:0] m;
    unique case (code)
      2'd0:    m = 8'h01;
      2'd1:    m = 8'h03;
      2'd2:    m = 8'h0F;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/lpe_if.sv @@
// Stream interfaces for the LSB payload extractor channels.
// Each carries valid, ready and one word of payload. No dependencies.
interface lpe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] image_byte;
  logic       start_image;

  modport source (output valid, output image_byte, output start_image, input ready);
  modport sink (input valid, input image_byte, input start_image, output ready);
endinterface

interface lpe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;

  modport source (output valid, output payload_byte, output last_byte, input ready);
  modport sink (input valid, input payload_byte, input last_byte, output ready);
endinterface

@@ rtl/lpe_core.sv @@
// Per-word extraction logic and stream state of the LSB payload extractor.
// Depends on lpe_pkg.
module lpe_core #(
  parameter int unsigned HEADER_BYTES = lpe_pkg::LPE_HEADER_BYTES
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    image_byte_i,
  input  logic          start_image_i,
  input  lpe_pkg::cfg_t cfg_i,
  output logic          res_valid_o,
  output logic [7:0]    payload_byte_o,
  output logic          last_byte_o
);
  import lpe_pkg::*;

  localparam int unsigned HIDX_W = $clog2(HEADER_BYTES + 1);

  logic [15:0]      col_q, col_d;
  logic [2:0]       chunk_q, chunk_d;
  logic [7:0]       asm_q, asm_d;
  logic [HIDX_W-1:0] hidx_q, hidx_d;
  logic [LEN_W-1:0] total_q, total_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic             fin_q, fin_d;

  logic [15:0]      col_e, chunk_dummy, ls, col_w;
  logic [2:0]       chunk_e;
  logic [7:0]       asm_e, asm_new, taken;
  logic [HIDX_W-1:0] hidx_e;
  logic [LEN_W-1:0] total_e, total_new, hidx_ext, rem_e;
  logic             fin_e, filter, complete;
  logic [16:0]      col_inc;
  logic [5:0]       sh;
  logic [3:0]       chunks, chunk_inc;

  assign chunk_dummy = '0;

  // Start flag clears the stream state before the word is used
  always_comb begin
    col_e   = start_image_i ? '0 : col_q;
    chunk_e = start_image_i ? '0 : chunk_q;
    asm_e   = start_image_i ? '0 : asm_q;
    hidx_e  = start_image_i ? '0 : hidx_q;
    total_e = start_image_i ? '0 : total_q;
    rem_e   = start_image_i ? '0 : rem_q;
    fin_e   = start_image_i ? 1'b0 : fin_q;
  end

  // Scanline position and filter byte detection
  assign ls      = (cfg_i.line_size < LINE_SIZE_MIN) ? LINE_SIZE_MIN : cfg_i.line_size;
  assign col_w   = (col_e >= ls) ? chunk_dummy : col_e;
  assign filter  = (col_w == '0);
  assign col_inc = {1'b0, col_w} + 17'd1;

  // Chunk placement inside the byte being rebuilt
  assign sh        = 6'(chunk_e) << cfg_i.bit_depth_code;
  assign taken     = image_byte_i & chunk_mask(cfg_i.bit_depth_code);
  assign asm_new   = (sh < 6'd8) ? (asm_e | (taken << sh[2:0])) : asm_e;
  assign chunks    = 4'd8 >> cfg_i.bit_depth_code;
  assign chunk_inc = {1'b0, chunk_e} + 4'd1;
  assign complete  = !(chunk_inc < chunks);

  // Header byte lands in its little-endian lane
  assign hidx_ext  = LEN_W'(hidx_e);
  assign total_new = (hidx_ext < 32'd4)
                     ? (total_e | (LEN_W'(asm_new) << {hidx_ext[1:0], 3'b000}))
                     : total_e;

  always_comb begin
    col_d          = (col_inc >= {1'b0, ls}) ? '0 : col_inc[15:0];
    chunk_d        = chunk_e;
    asm_d          = asm_e;
    hidx_d         = hidx_e;
    total_d        = total_e;
    rem_d          = rem_e;
    fin_d          = fin_e;
    res_valid_o    = 1'b0;
    payload_byte_o = asm_new;
    last_byte_o    = (rem_e == LEN_W'(1));
    if (!filter && !fin_e) begin
      if (!complete) begin
        chunk_d = chunk_inc[2:0];
        asm_d   = asm_new;
      end else begin
        chunk_d = '0;
        asm_d   = '0;
        if (hidx_ext < LEN_W'(HEADER_BYTES)) begin
          // Collect the length header
          total_d = total_new;
          hidx_d  = hidx_e + HIDX_W'(1);
          if (hidx_ext + LEN_W'(1) == LEN_W'(HEADER_BYTES)) begin
            if (total_new <= LEN_W'(HEADER_BYTES)) begin
              fin_d = 1'b1;
              rem_d = '0;
            end else begin
              rem_d = total_new - LEN_W'(HEADER_BYTES);
            end
          end
        end else if (rem_e == '0) begin
          fin_d = 1'b1;
        end else begin
          // Emit one payload word
          rem_d       = rem_e - LEN_W'(1);
          res_valid_o = 1'b1;
          if (rem_e == LEN_W'(1)) begin
            fin_d = 1'b1;
          end
        end
      end
    end
  end

  // Advance the stream state on each processed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      chunk_q <= '0;
      asm_q   <= '0;
      hidx_q  <= '0;
      total_q <= '0;
      rem_q   <= '0;
      fin_q   <= 1'b0;
    end else if (step_i) begin
      col_q   <= col_d;
      chunk_q <= chunk_d;
      asm_q   <= asm_d;
      hidx_q  <= hidx_d;
      total_q <= total_d;
      rem_q   <= rem_d;
      fin_q   <= fin_d;
    end
  end

endmodule

@@ rtl/lsb_payload_extractor_unit.sv @@
// Top level of the LSB payload extractor: config registers, input and result registers.
// Depends on lpe_pkg, lpe_if (lpe_in_if, lpe_out_if) and lpe_core.
//
//   channel  | dir | word                        | handshake
//   ---------+-----+-----------------------------+-------------------------
//   in_i     | in  | image_byte, start_image     | valid/ready
//   out_o    | out | payload_byte, last_byte     | valid/ready
//   APB      | in  | bit_depth_code, line_size   | psel/penable, pready=1
//
// One image word per cycle unless the result register stalls; a word's payload byte, if
// any, moves from the input register to the result register via the extraction logic.
// Reset clears the stream state as if an image had just started.
// A stalled result register holds the input register; ready drops only then.
module lsb_payload_extractor_unit #(
  parameter int unsigned HEADER_BYTES = lpe_pkg::LPE_HEADER_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpe_in_if.sink      in_i,
  lpe_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lpe_pkg::*;

  cfg_t       cfg_q;
  logic       cfg_we;
  logic       s_valid_q;
  logic [7:0] s_byte_q;
  logic       s_start_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       out_free, step, in_take;
  logic       res_valid, res_last;
  logic [7:0] res_byte;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_depth_code <= 2'd0;
      cfg_q.line_size      <= LINE_SIZE_MIN;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_BIT_DEPTH: cfg_q.bit_depth_code <= pwdata[1:0];
        REG_LINE_SIZE: cfg_q.line_size      <= pwdata[15:0];
        default:       cfg_q                <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BIT_DEPTH: prdata = {30'd0, cfg_q.bit_depth_code};
      REG_LINE_SIZE: prdata = {16'd0, cfg_q.line_size};
      default:       prdata = '0;
    endcase
  end

  // Handshake control
  assign out_free   = !out_valid_q || out_o.ready;
  assign step       = s_valid_q && out_free;
  assign in_i.ready = !s_valid_q || out_free;
  assign in_take    = in_i.valid && in_i.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_take) begin
      s_valid_q <= 1'b1;
    end else if (step) begin
      s_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s_byte_q  <= in_i.image_byte;
      s_start_q <= in_i.start_image;
    end
  end

  lpe_core #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .image_byte_i  (s_byte_q),
    .start_image_i (s_start_q),
    .cfg_i         (cfg_q),
    .res_valid_o   (res_valid),
    .payload_byte_o(res_byte),
    .last_byte_o   (res_last)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid && out_free) begin
      out_byte_q <= res_byte;
      out_last_q <= res_last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.payload_byte = out_byte_q;
  assign out_o.last_byte    = out_last_q;

endmodule

@@ rtl/lpe_checker.sv @@
// Port-level assertions for the LSB payload extractor, bound to the top level.
// Depends on lsb_payload_extractor_unit and its channel interfaces.
module lpe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_payload,
  input logic       out_last
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_payload) && $stable(out_last))
    else $error("result word changed while stalled");

  // Input side stalls only behind a stalled result
  a_ready_decoupled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  // A new result appears only when the input side was open just before
  a_rise_after_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_ready))
    else $error("result rose after a closed input cycle");

endmodule

bind lsb_payload_extractor_unit lpe_checker u_lpe_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_payload(out_o.payload_byte),
  .out_last   (out_o.last_byte)
);

@@ test/lsb_payload_extractor_unit_test.sv @@
// Self-checking testbench for lsb_payload_extractor_unit: stream words in, check payload words out.
// Depends on lpe_pkg, lpe_in_if / lpe_out_if and the unit itself; a directed table (fixed rows
// give expected words), then random images under many settings, predicted by an in-bench model.
module lsb_payload_extractor_unit_test;
  import lpe_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_WORDS = 1000;
  localparam int unsigned IDLE_PCT     = 34;
  localparam int unsigned LIMIT_TIME   = 4000000;

  typedef struct packed {
    logic [7:0] payload;
    logic       last;
  } result_t;

  typedef enum logic [1:0] {ROW_WORD, ROW_FIXED, ROW_CFG} row_kind_e;

  // kind, image byte, start, register, value, result expected, payload, last
  typedef struct packed {
    row_kind_e   kind;
    logic [7:0]  data;
    logic        start;
    logic        reg_sel;
    logic [31:0] value;
    logic        has;
    logic [7:0]  payload;
    logic        last;
  } dir_row_t;

  localparam int unsigned NUM_ROWS = 28;
  localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
    // full-byte depth, one line of the largest size
    '{ROW_CFG,   8'h00, 1'b0, REG_BIT_DEPTH, 32'd3,     1'b0, 8'h00, 1'b0},
    '{ROW_CFG,   8'h00, 1'b0, REG_LINE_SIZE, 32'hFFFF,  1'b0, 8'h00, 1'b0},
    // no start flag after reset: length 5, one payload word, then ignored
    '{ROW_FIXED, 8'hC3, 1'b0, REG_BIT_DEPTH, 32'd0,     1'b0, 8'h00, 1'b0},
    '{ROW_FIXED, 8'h05, 1'b0, REG_BIT_DEPTH, 32'd0,     1'b0, 8'h00, 1'b0},
    '{ROW_FIXED, 8'h00, 1'b0, REG_BIT_DEPTH, 32'd0,     1'b0, 8'h00, 1'b0},
    '{ROW_FIXED, 8'h00, 1'b0, REG_BIT_DEPTH, 32'd0,     1'b0, 8'h00, 1'b0},
    '{ROW_FIXED, 8'h00, 1'b0, REG_BIT_DEPTH, 32'd0,     1'b0, 8'h00, 1'b0},
    '{ROW_FIXED, 8'hFF, 1'b0, REG_BIT_DEPTH, 32'd0,     1'b1, 8'hFF, 1'b1},
    '{ROW_FIXED, 8'h77, 1'b0, REG_BIT_DEPTH, 32'd0,     1'b0, 8'h00, 1'b0},
    // zero length: finished at once
    '{ROW_FIXED, 8'hA5, 1'b1, REG_BIT_DEPTH, 32'd0,     1'b0, 8'h00, 1'b0},
    '{ROW_FIXED, 8'h00, 1'b0, REG_BIT_DEPTH, 32'd0,     1'b0, 8'h00, 1'b0},
    '{ROW_FIXED, 8'h00, 1'b0, REG_BIT_DEPTH, 32'd0,     1'b0, 8'h00, 1'b0},
    '{ROW_FIXED, 8'h00, 1'b0, REG_BIT_DEPTH, 32'd0,     1'b0, 8'h00, 1'b0},
    '{ROW_FIXED, 8'h00, 1'b0, REG_BIT_DEPTH, 32'd0,     1'b0, 8'h00, 1'b0},
    // largest length, payload extremes
    '{ROW_FIXED, 8'hFF, 1'b1, REG_BIT_DEPTH, 32'd0,     1'b0, 8'h00, 1'b0},
    '{ROW_FIXED, 8'hFF, 1'b0, REG_BIT_DEPTH, 32'd0,     1'b0, 8'h00, 1'b0},
    '{ROW_FIXED, 8'hFF, 1'b0, REG_BIT_DEPTH, 32'd0,     1'b0, 8'h00, 1'b0},
    '{ROW_FIXED, 8'hFF, 1'b0, REG_BIT_DEPTH, 32'd0,     1'b0, 8'h00, 1'b0},
    '{ROW_FIXED, 8'hFF, 1'b0, REG_BIT_DEPTH, 32'd0,     1'b0, 8'h00, 1'b0},
    '{ROW_FIXED, 8'h00, 1'b0, REG_BIT_DEPTH, 32'd0,     1'b1, 8'h00, 1'b0},
    '{ROW_FIXED, 8'hFF, 1'b0, REG_BIT_DEPTH, 32'd0,     1'b1, 8'hFF, 1'b0},
    // short line size, lowered below the current column, nibble depth
    '{ROW_CFG,   8'h00, 1'b0, REG_LINE_SIZE, 32'd1,     1'b0, 8'h00, 1'b0},
    '{ROW_CFG,   8'h00, 1'b0, REG_BIT_DEPTH, 32'd2,     1'b0, 8'h00, 1'b0},
    '{ROW_WORD,  8'h5C, 1'b0, REG_BIT_DEPTH, 32'd0,     1'b0, 8'h00, 1'b0},
    '{ROW_WORD,  8'hA3, 1'b0, REG_BIT_DEPTH, 32'd0,     1'b0, 8'h00, 1'b0},
    // depth raised in the middle of a byte
    '{ROW_CFG,   8'h00, 1'b0, REG_BIT_DEPTH, 32'd3,     1'b0, 8'h00, 1'b0},
    '{ROW_WORD,  8'h11, 1'b0, REG_BIT_DEPTH, 32'd0,     1'b0, 8'h00, 1'b0},
    '{ROW_WORD,  8'hF6, 1'b0, REG_BIT_DEPTH, 32'd0,     1'b0, 8'h00, 1'b0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] cfg_rdata;
  logic        pready;

  lpe_in_if  in_bus ();
  lpe_out_if out_bus ();

  lsb_payload_extractor_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (cfg_rdata),
    .pready  (pready)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Extractor model state and its copy of the registers
  logic [15:0]       col_cnt;
  logic [2:0]        chunk_cnt;
  logic [7:0]        asm_byte;
  int unsigned       hdr_cnt;
  logic [LEN_W-1:0]  len_acc;
  logic [LEN_W-1:0]  bytes_left;
  logic              done_flag;
  logic [1:0]        depth_code;
  logic [15:0]       line_len;

  result_t     pending_bytes [$];
  int unsigned errors;
  int unsigned words_sent;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  logic        hold_req;

  function automatic void restart_stream();
    col_cnt    = '0;
    chunk_cnt  = '0;
    asm_byte   = '0;
    hdr_cnt    = 0;
    len_acc    = '0;
    bytes_left = '0;
    done_flag  = 1'b0;
  endfunction

  // Advance the model by one image word; return 1 when it yields a payload word
  function automatic logic extract_step(input logic [7:0] b, input logic s, output result_t r);
    int unsigned ls;
    int unsigned bits;
    int unsigned chunks;
    int unsigned sh;
    int unsigned mask;
    logic        filter;
    logic [7:0]  full;
    r  = '0;
    ls = (line_len < LINE_SIZE_MIN) ? 2 : int'(line_len);
    if (s) restart_stream();
    if (32'(col_cnt) >= ls) col_cnt = '0;
    filter  = (col_cnt == 16'd0);
    col_cnt = (32'(col_cnt) + 1 >= ls) ? 16'd0 : col_cnt + 16'd1;
    if (filter || done_flag) return 1'b0;

    bits   = 1 << depth_code;
    chunks = 8 >> depth_code;
    mask   = (1 << bits) - 1;
    sh     = int'(chunk_cnt) * bits;
    if (sh < 8) asm_byte = 8'(asm_byte | ((b & mask) << sh));
    if (32'(chunk_cnt) + 1 < chunks) begin
      chunk_cnt = chunk_cnt + 3'd1;
      return 1'b0;
    end

    full      = asm_byte;
    chunk_cnt = '0;
    asm_byte  = '0;

    // Gather the little-endian length
    if (hdr_cnt < LPE_HEADER_BYTES) begin
      if (hdr_cnt < 4) len_acc = len_acc | (LEN_W'(full) << (8 * hdr_cnt));
      hdr_cnt++;
      if (hdr_cnt == LPE_HEADER_BYTES) begin
        if (len_acc <= LPE_HEADER_BYTES) begin
          done_flag  = 1'b1;
          bytes_left = '0;
        end else begin
          bytes_left = len_acc - LPE_HEADER_BYTES;
        end
      end
      return 1'b0;
    end

    if (bytes_left == '0) begin
      done_flag = 1'b1;
      return 1'b0;
    end
    bytes_left = bytes_left - 1;
    r.payload  = full;
    r.last     = (bytes_left == '0);
    if (r.last) done_flag = 1'b1;
    return 1'b1;
  endfunction

  // Offer one word, wait for the handshake and run the model on it
  task automatic send_word(input logic [7:0] b, input logic s, output logic got,
                           output result_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.image_byte  <= b;
    in_bus.start_image <= s;
    do @(posedge clk_i); while (!in_bus.ready);
    words_sent++;
    got = extract_step(b, s, r);
  endtask

  task automatic offer_word(input logic [7:0] b, input logic s);
    logic    got;
    result_t r;
    send_word(b, s, got, r);
    if (got) pending_bytes.push_back(r);
  endtask

  // Drop valid and wait until the unit has nothing left in flight
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Setup and access cycle, then release the bus and read back
  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] want;
    want = (idx == REG_BIT_DEPTH) ? {30'd0, value[1:0]} : {16'd0, value[15:0]};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_BIT_DEPTH) depth_code = value[1:0];
    else line_len = value[15:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    // The address still points at the register just written
    if (cfg_rdata !== want) begin
      $display("%0t: register %0d expected %08h actual %08h", $time, idx, want, cfg_rdata);
      errors++;
    end
  endtask

  // One image: start word as the first filter byte, length header, payload, trailing words
  task automatic send_image();
    logic [7:0]  rebuilt [$];
    logic [31:0] len;
    logic [7:0]  v;
    int unsigned mode;
    int unsigned plen;
    int unsigned bits;
    int unsigned chunks;
    int unsigned mask;
    int unsigned ls;
    mode = $urandom_range(99);
    plen = $urandom_range(1, (depth_code == 2'd0) ? 3 : 10);
    if (mode < 12) len = $urandom_range(LPE_HEADER_BYTES);
    else if (mode < 17) len = {1'b1, 31'($urandom)};
    else len = plen + LPE_HEADER_BYTES;
    for (int i = 0; i < int'(LPE_HEADER_BYTES); i++) rebuilt.push_back(len[8*(i%4) +: 8]);
    repeat (plen) rebuilt.push_back(8'($urandom));
    // broken image: cut it short
    if ($urandom_range(99) < 10) begin
      mode = $urandom_range(rebuilt.size() - 1);
      while (rebuilt.size() > mode) void'(rebuilt.pop_back());
    end

    offer_word(8'($urandom), 1'b1);
    bits   = 1 << depth_code;
    chunks = 8 >> depth_code;
    mask   = (1 << bits) - 1;
    foreach (rebuilt[i]) begin
      v = rebuilt[i];
      for (int c = 0; c < int'(chunks); c++) begin
        // skip filter columns so each chunk lands on a data byte
        ls = (line_len < LINE_SIZE_MIN) ? 2 : int'(line_len);
        while (col_cnt == 16'd0 || 32'(col_cnt) >= ls) offer_word(8'($urandom), 1'b0);
        offer_word(8'(($urandom & ~mask) | ((v >> (c * bits)) & mask)), 1'b0);
      end
    end
    repeat ($urandom_range(3)) offer_word(8'($urandom), 1'b0);
  endtask

  // Result side: check each word against the oldest expectation, idle and hold off
  initial begin
    int unsigned hold_left;
    logic        hold_done;
    result_t     want;
    hold_left = 0;
    hold_done = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_bus.valid && out_bus.ready) begin
        if (pending_bytes.size() == 0) begin
          $display("%0t: unexpected payload word %02h last %0b", $time,
                   out_bus.payload_byte, out_bus.last_byte);
          errors++;
        end else begin
          want = pending_bytes.pop_front();
          if (out_bus.payload_byte !== want.payload) begin
            $display("%0t: payload_byte expected %02h actual %02h", $time,
                     want.payload, out_bus.payload_byte);
            errors++;
          end
          if (out_bus.last_byte !== want.last) begin
            $display("%0t: last_byte expected %0b actual %0b", $time,
                     want.last, out_bus.last_byte);
            errors++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    #(LIMIT_TIME);
    $display("lsb_payload_extractor_unit_test: done, errors");
    $finish;
  end

  // Stimulus: reset, directed table, then random phases with new settings
  initial begin
    dir_row_t    row;
    logic        got;
    result_t     r;
    int unsigned phase;
    int unsigned phase_end;
    logic [1:0]  new_depth;
    logic [15:0] new_line;
    int unsigned pick;
    errors       = 0;
    words_sent   = 0;
    tx_idle_pct  = IDLE_PCT;
    rx_idle_pct  = IDLE_PCT;
    hold_req     = 1'b0;
    depth_code   = 2'd0;
    line_len     = LINE_SIZE_MIN;
    restart_stream();
    rst_ni             <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.image_byte  <= 8'h00;
    in_bus.start_image <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[i]) begin
      row = DIR_ROWS[i];
      case (row.kind)
        ROW_CFG: begin
          settle();
          write_reg(row.reg_sel, row.value);
        end
        ROW_WORD: offer_word(row.data, row.start);
        default: begin
          send_word(row.data, row.start, got, r);
          if (row.has) pending_bytes.push_back('{payload: row.payload, last: row.last});
        end
      endcase
    end
    settle();

    phase = 0;
    while (words_sent < RANDOM_WORDS) begin
      // Pick this phase's settings, extremes first
      if (phase == 0) begin
        new_depth = 2'd0;
        new_line  = LINE_SIZE_MIN;
      end else if (phase == 1) begin
        new_depth = 2'd3;
        new_line  = 16'hFFFF;
      end else begin
        new_depth = 2'($urandom_range(3));
        pick      = $urandom_range(99);
        if (pick < 8) new_line = 16'($urandom_range(1));
        else if (pick < 70) new_line = 16'($urandom_range(2, 9));
        else if (pick < 85) new_line = 16'($urandom_range(10, 40));
        else if (pick < 93) new_line = 16'hFFFF;
        else new_line = 16'($urandom);
      end
      write_reg(REG_BIT_DEPTH, {30'($urandom), new_depth});
      if (phase < 2 || $urandom_range(99) >= 20) write_reg(REG_LINE_SIZE, {16'($urandom), new_line});

      tx_idle_pct = (phase == 2) ? 0 : IDLE_PCT;
      rx_idle_pct = tx_idle_pct;
      if (phase == 1) hold_req = 1'b1;

      phase_end = words_sent + $urandom_range(60, 140);
      while (words_sent < phase_end) begin
        if ($urandom_range(99) < 75) begin
          send_image();
        end else begin
          repeat ($urandom_range(1, 12)) offer_word(8'($urandom), $urandom_range(99) < 8);
        end
      end
      settle();
      phase++;
    end

    if (errors == 0 && pending_bytes.size() == 0) begin
      $display("lsb_payload_extractor_unit_test: done, clean");
    end else begin
      $display("lsb_payload_extractor_unit_test: done, errors");
    end
    $finish;
  end

endmodule
